FILE: sv/ttcm_pkg.sv
// ----------------------------------------------------------------------------
// ttcm_pkg: shared definitions for the tilt to controller messages unit
// Field widths, controller numbers and the two tilt mapping tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcm_pkg;

   localparam int AXIS_W   = 16;
   localparam int CC_NUM_W = 3;
   localparam int CC_VAL_W = 7;
   localparam int IDX_W    = 5;
   localparam int MOD_W    = 5;

   localparam logic [CC_NUM_W-1:0] CC_MODULATION = 3'd1;
   localparam logic [CC_NUM_W-1:0] CC_PORTAMENTO = 3'd5;

   // modulation depth for each inclination index (31 is level)
   localparam logic [MOD_W-1:0] MOD_DEPTH [32] = '{
      5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd2,  5'd2,
      5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
      5'd12, 5'd14, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31
   };

   // portamento time for each inclination index
   localparam logic [CC_VAL_W-1:0] PRT_DEPTH [32] = '{
      7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
      7'd10,  7'd20,  7'd30,  7'd40,  7'd50,  7'd60,  7'd70,  7'd70,
      7'd80,  7'd80,  7'd80,  7'd80,  7'd90,  7'd90,  7'd90,  7'd90,
      7'd100, 7'd100, 7'd100, 7'd100, 7'd110, 7'd110, 7'd110, 7'd110
   };

   typedef struct packed {
      logic [CC_NUM_W-1:0] number;
      logic [CC_VAL_W-1:0] value;
      logic                last;
   } cc_msg_type;

endpackage

`default_nettype wire

FILE: sv/tilt_to_controller_messages_unit.sv
// ----------------------------------------------------------------------------
// tilt_to_controller_messages_unit: tilt sample to control-change messages
// Turns one X/Z accelerometer sample into zero, one or two controller
// updates (modulation, then portamento time).
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one sample (accel_x, accel_z) per transfer. The
//   sample is captured in an input register; it is then mapped to controller
//   messages, the state is updated and the messages are loaded into a
//   two-entry output buffer, once that buffer is empty or drains its last
//   entry. rsp_ channel delivers one message per transfer, rsp_last_of_run
//   marking the final one of a sample. A sample that changes nothing yields
//   no transfer on rsp_. A sample passes the input register and then the
//   output buffer before its first rsp_ transfer. Throughput: one sample
//   per cycle while samples yield at most one message and the receiver
//   does not stall; two messages drain through one port, one entry per cycle.
//   When the receiver stalls, the buffer and then the input register hold,
//   and req_ready drops. Reset empties both stages and clears the modulation
//   and portamento values to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_to_controller_messages_unit
   import ttcm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic signed [AXIS_W-1:0]   req_accel_x,
   input  wire logic signed [AXIS_W-1:0]   req_accel_z,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [CC_NUM_W-1:0]        rsp_controller_number,
   output      logic [CC_VAL_W-1:0]        rsp_controller_value,
   output      logic                       rsp_last_of_run
);

   // input register
   logic                     s1_valid_ff;
   logic signed [AXIS_W-1:0] s1_x_ff;
   logic                     s1_z_neg_ff;

   // state
   logic [MOD_W-1:0]    cur_mod_ff, cur_mod_in;
   logic [CC_VAL_W-1:0] cur_prt_ff, cur_prt_in;

   // output buffer, entry 0 is the head
   cc_msg_type   buf0_ff, buf1_ff;
   logic [1:0]   count_ff;

   logic          pop;
   logic          advance;
   logic [AXIS_W-2:0] mag;
   logic [5:0]    quot;
   logic [IDX_W-1:0] idx, mod_idx, prt_idx;
   logic [MOD_W-1:0] mod_target;
   logic [CC_VAL_W-1:0] prt_target;
   logic          mod_chg, prt_chg;
   cc_msg_type    mod_msg, prt_msg, new0, new1;
   logic [1:0]    new_count;

   // handshake: stage 1 moves on once the buffer is empty or drains its last entry
   assign pop       = rsp_valid && rsp_ready;
   assign advance   = s1_valid_ff && (count_ff == 2'd0 || (count_ff == 2'd1 && pop));
   assign req_ready = !s1_valid_ff || advance;

   // capture the sample
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s1_x_ff     <= req_accel_x;
         s1_z_neg_ff <= req_accel_z[AXIS_W-1];
      end
   end

   // magnitude of X, most negative value saturated
   always_comb begin
      if (s1_x_ff[AXIS_W-1]) begin
         if (s1_x_ff[AXIS_W-2:0] == '0) begin
            mag = '1;
         end else begin
            mag = (AXIS_W-1)'(-s1_x_ff);
         end
      end else begin
         mag = s1_x_ff[AXIS_W-2:0];
      end
   end

   // inclination index: divide by 512, invert, saturate large tilt to 0
   assign quot    = mag[AXIS_W-2:9];
   assign idx     = quot[5] ? '0 : ~quot[IDX_W-1:0];
   assign mod_idx = s1_z_neg_ff ? '0 : idx;
   assign prt_idx = s1_z_neg_ff ? idx : '0;

   assign mod_target = MOD_DEPTH[mod_idx];
   assign prt_target = PRT_DEPTH[prt_idx];

   // slew modulation one step, jump portamento
   always_comb begin
      cur_mod_in = cur_mod_ff;
      mod_chg    = 1'b0;
      if (mod_target > cur_mod_ff) begin
         cur_mod_in = cur_mod_ff + MOD_W'(1);
         mod_chg    = 1'b1;
      end else if (mod_target < cur_mod_ff) begin
         cur_mod_in = cur_mod_ff - MOD_W'(1);
         mod_chg    = 1'b1;
      end
      prt_chg    = (prt_target != cur_prt_ff);
      cur_prt_in = prt_target;
   end

   // order the messages: modulation first
   always_comb begin
      mod_msg.number = CC_MODULATION;
      mod_msg.value  = {2'b00, cur_mod_in};
      mod_msg.last   = !prt_chg;
      prt_msg.number = CC_PORTAMENTO;
      prt_msg.value  = cur_prt_in;
      prt_msg.last   = 1'b1;
      new0      = mod_chg ? mod_msg : prt_msg;
      new1      = prt_msg;
      new_count = {1'b0, mod_chg} + {1'b0, prt_chg};
   end

   // update state on each sample
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mod_ff <= '0;
         cur_prt_ff <= '0;
      end else if (advance) begin
         cur_mod_ff <= cur_mod_in;
         cur_prt_ff <= cur_prt_in;
      end
   end

   // load or drain the output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (advance) begin
         count_ff <= new_count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
      if (advance) begin
         buf0_ff <= new0;
         buf1_ff <= new1;
      end else if (pop) begin
         buf0_ff <= buf1_ff;
      end
   end

   assign rsp_valid             = (count_ff != 2'd0);
   assign rsp_controller_number = buf0_ff.number;
   assign rsp_controller_value  = buf0_ff.value;
   assign rsp_last_of_run       = buf0_ff.last;

endmodule

`default_nettype wire

FILE: sv/ttcm_checker.sv
// ----------------------------------------------------------------------------
// ttcm_checker: port-level checks for tilt_to_controller_messages_unit
// Watches the result channel for legal messages and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcm_checker
   import ttcm_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [CC_NUM_W-1:0]      rsp_controller_number,
   input wire logic [CC_VAL_W-1:0]      rsp_controller_value,
   input wire logic                     rsp_last_of_run
);

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // only the two known controllers
   a_known_cc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_controller_number == CC_MODULATION ||
                     rsp_controller_number == CC_PORTAMENTO))
      else $error("unknown controller number");

   // modulation stays within its five-bit range
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_controller_number == CC_MODULATION)
         |-> rsp_controller_value[6:5] == 2'b00)
      else $error("modulation value out of range");

   // a portamento message always closes its sample
   a_prt_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_controller_number == CC_PORTAMENTO) |-> rsp_last_of_run)
      else $error("portamento message not last of its sample");

   // a stalled message holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_controller_number)
         && $stable(rsp_controller_value) && $stable(rsp_last_of_run)))
      else $error("stalled message changed");

endmodule

bind tilt_to_controller_messages_unit ttcm_checker u_ttcm_checker (.*);

`default_nettype wire
